// ----- rtl/seu_pkg.sv -----
package seu_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam int BYTE_W    = 8;
  localparam int READING_W = 16;
  localparam int TURN_W    = 8;
  localparam int POS_W     = 21;
  localparam int ANGLE_W   = 25;
  localparam int CHAN_W    = 2;
  localparam int TURN_SHIFT  = 12;  // one turn is 4096 counts
  localparam int ANGLE_SHIFT = 4;   // angle = position * 15 = (position << 4) - position

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LOW  = 2'd2;

  localparam logic [BYTE_W-1:0]    HEADER_RESET    = 8'h73;
  localparam logic [READING_W-1:0] WRAP_HIGH_RESET = 16'd3000;
  localparam logic [READING_W-1:0] WRAP_LOW_RESET  = 16'd1000;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/seu_front.sv -----
module seu_front #(
  parameter int CHANNELS = seu_pkg::CHANNELS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  logic [seu_pkg::BYTE_W-1:0]                in_rx_byte,
  output logic                                      in_stall,
  input  logic [seu_pkg::BYTE_W-1:0]                header_byte,
  input  seu_pkg::q_status_t                        q_status,
  output logic                                      push,
  output logic [CHANNELS-1:0][seu_pkg::READING_W-1:0] push_data
);

  localparam int DATA_BYTES = 2 * CHANNELS;
  localparam int PH_W       = $clog2(DATA_BYTES + 2);
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [PH_W-1:0] PH_HUNT = '0;
  localparam logic [PH_W-1:0] PH_CSUM = PH_W'(DATA_BYTES + 1);

  logic [PH_W-1:0]                 phase_r, phase_nxt;
  logic [seu_pkg::BYTE_W-1:0]      csum_r, csum_nxt;
  logic [seu_pkg::READING_W-1:0]   readings_r [CHANNELS];
  logic [PH_W-1:0]                 k;
  logic [CH_W-1:0]                 ch;
  logic                            accept;

  // Only the checksum word can produce a frame, so only it waits on a full queue.
  assign in_stall = q_status.full && (phase_r == PH_CSUM);
  assign accept   = in_valid && !in_stall;
  assign k        = phase_r - PH_W'(1);
  assign ch       = k[CH_W:1];

  always_comb begin
    phase_nxt = phase_r;
    csum_nxt  = csum_r;
    push      = 1'b0;
    if (accept) begin
      if (phase_r == PH_HUNT) begin
        if (in_rx_byte == header_byte) begin
          phase_nxt = PH_W'(1);
          csum_nxt  = '0;
        end
      end else if (phase_r == PH_CSUM) begin
        phase_nxt = PH_HUNT;
        push      = (in_rx_byte == csum_r);
      end else begin
        csum_nxt  = csum_r ^ in_rx_byte;
        phase_nxt = phase_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      csum_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      csum_r  <= csum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r != PH_HUNT && phase_r != PH_CSUM) begin
      if (!k[0]) begin
        readings_r[ch][15:8] <= in_rx_byte;
      end else begin
        readings_r[ch][7:0] <= in_rx_byte;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      push_data[i] = readings_r[i];
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CSUM)
    else $error("frame phase beyond the checksum word");

endmodule

// ----- rtl/seu_queue.sv -----
module seu_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = seu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   head_data,
  output seu_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("frame queue read while empty");

endmodule

// ----- rtl/seu_back.sv -----
module seu_back #(
  parameter int CHANNELS = seu_pkg::CHANNELS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  seu_pkg::q_status_t                          q_status,
  input  logic [CHANNELS-1:0][seu_pkg::READING_W-1:0] head_data,
  output logic                                        pop,
  input  logic [seu_pkg::READING_W-1:0]               wrap_high,
  input  logic [seu_pkg::READING_W-1:0]               wrap_low,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [seu_pkg::CHAN_W-1:0]                  out_channel,
  output logic [seu_pkg::READING_W-1:0]               out_raw_reading,
  output logic signed [seu_pkg::TURN_W-1:0]           out_turn_count,
  output logic signed [seu_pkg::POS_W-1:0]            out_position,
  output logic signed [seu_pkg::ANGLE_W-1:0]          out_angle_q9,
  output logic                                        out_last
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW   = seu_pkg::READING_W;
  localparam int TW   = seu_pkg::TURN_W;
  localparam int PW   = seu_pkg::POS_W;
  localparam int AW   = seu_pkg::ANGLE_W;

  logic [CH_W-1:0] ch_r;
  logic [RW-1:0]   prev_r  [CHANNELS];
  logic [TW-1:0]   turns_r [CHANNELS];

  logic                   out_valid_r, out_valid_nxt;
  logic [seu_pkg::CHAN_W-1:0] out_channel_r;
  logic [RW-1:0]          out_raw_r;
  logic [TW-1:0]          out_turn_r;
  logic [PW-1:0]          out_pos_r;
  logic                   out_last_r;

  logic          advance, last_ch, inc, dec;
  logic [RW-1:0] r, p;
  logic [TW-1:0] t, t_nxt;
  logic [PW-1:0] pos_nxt;
  logic [AW-1:0] pos_ext;

  assign advance = !q_status.empty && (!out_valid_r || !out_stall);
  assign last_ch = (ch_r == CH_W'(CHANNELS - 1));
  assign pop     = advance && last_ch;

  assign r   = head_data[ch_r];
  assign p   = prev_r[ch_r];
  assign t   = turns_r[ch_r];
  assign inc = (p > wrap_high) && (r < wrap_low);
  assign dec = (p < wrap_low) && (r > wrap_high);

  // When the thresholds overlap, both crossings may fire and cancel out.
  always_comb begin
    t_nxt = t;
    if (inc && !dec) begin
      t_nxt = t + TW'(1);
    end else if (dec && !inc) begin
      t_nxt = t - TW'(1);
    end
  end

  assign pos_nxt = {t_nxt[TW-1], t_nxt, {seu_pkg::TURN_SHIFT{1'b0}}} + PW'(r);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_r[i]  <= '0;
        turns_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        ch_r          <= last_ch ? '0 : ch_r + CH_W'(1);
        prev_r[ch_r]  <= r;
        turns_r[ch_r] <= t_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_r <= seu_pkg::CHAN_W'(ch_r);
      out_raw_r     <= r;
      out_turn_r    <= t_nxt;
      out_pos_r     <= pos_nxt;
      out_last_r    <= last_ch;
    end
  end

  assign pos_ext         = {{(AW - PW){out_pos_r[PW-1]}}, out_pos_r};
  assign out_angle_q9    = (pos_ext << seu_pkg::ANGLE_SHIFT) - pos_ext;
  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_raw_reading = out_raw_r;
  assign out_turn_count  = out_turn_r;
  assign out_position    = out_pos_r;
  assign out_last        = out_last_r;

  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_channel_r == seu_pkg::CHAN_W'(CHANNELS - 1)))
    else $error("last word of a frame carries the wrong channel");

endmodule

// ----- rtl/steer_encoder_frame_unwrap_core.sv -----
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_rx_byte
// out      output     out_valid/out_stall out_channel, out_raw_reading, out_turn_count,
//                                         out_position, out_angle_q9, out_last
// cfg      input      cfg_wr_en           cfg_index, cfg_wdata
//
// The front takes one byte every cycle; it stalls only on a checksum byte while the
// frame queue already holds QDEPTH frames.
// The back emits one result word per cycle from the queue head, CHANNELS words per frame,
// and holds its output register while out_stall is high, so a full queue then stalls the front.
// Without output stalls a frame of 2*CHANNELS+2 bytes therefore flows through at full rate.
// Reset is synchronous: hunting for a header, turn counters and previous readings at zero,
// configuration registers at their reset values.
module steer_encoder_frame_unwrap_core #(
  parameter int CHANNELS = seu_pkg::CHANNELS_DEF,
  parameter int QDEPTH   = seu_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [seu_pkg::BYTE_W-1:0]          in_rx_byte,
  output logic                                in_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [seu_pkg::CHAN_W-1:0]          out_channel,
  output logic [seu_pkg::READING_W-1:0]       out_raw_reading,
  output logic signed [seu_pkg::TURN_W-1:0]   out_turn_count,
  output logic signed [seu_pkg::POS_W-1:0]    out_position,
  output logic signed [seu_pkg::ANGLE_W-1:0]  out_angle_q9,
  output logic                                out_last,
  input  logic                                cfg_wr_en,
  input  logic [seu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [seu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int RW = seu_pkg::READING_W;

  logic [seu_pkg::BYTE_W-1:0] header_r;
  logic [RW-1:0]              wrap_high_r;
  logic [RW-1:0]              wrap_low_r;

  seu_pkg::q_status_t           q_status;
  logic                         push, pop;
  logic [CHANNELS-1:0][RW-1:0]  push_data;
  logic [CHANNELS-1:0][RW-1:0]  head_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= seu_pkg::HEADER_RESET;
      wrap_high_r <= seu_pkg::WRAP_HIGH_RESET;
      wrap_low_r  <= seu_pkg::WRAP_LOW_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        seu_pkg::CFG_HEADER:    header_r    <= cfg_wdata[seu_pkg::BYTE_W-1:0];
        seu_pkg::CFG_WRAP_HIGH: wrap_high_r <= cfg_wdata[RW-1:0];
        seu_pkg::CFG_WRAP_LOW:  wrap_low_r  <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  seu_front #(.CHANNELS(CHANNELS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_rx_byte  (in_rx_byte),
    .in_stall    (in_stall),
    .header_byte (header_r),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  seu_queue #(.WIDTH(CHANNELS * RW), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  seu_back #(.CHANNELS(CHANNELS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .head_data       (head_data),
    .pop             (pop),
    .wrap_high       (wrap_high_r),
    .wrap_low        (wrap_low_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel     (out_channel),
    .out_raw_reading (out_raw_reading),
    .out_turn_count  (out_turn_count),
    .out_position    (out_position),
    .out_angle_q9    (out_angle_q9),
    .out_last        (out_last)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

import seu_pkg::*;

typedef struct packed {
  logic [CHAN_W-1:0]           channel;
  logic [READING_W-1:0]        raw_reading;
  logic signed [TURN_W-1:0]    turn_count;
  logic signed [POS_W-1:0]     position;
  logic signed [ANGLE_W-1:0]   angle_q9;
  logic                        last;
} wheel_result_t;

// Follows the frame receiver byte by byte and queues the wheel positions that a good
// frame is due to produce.
class wheel_position_tracker;
  logic [BYTE_W-1:0]           header_byte;
  logic [READING_W-1:0]        wrap_high;
  logic [READING_W-1:0]        wrap_low;
  int unsigned                 frame_pos;
  logic [BYTE_W-1:0]           xor_fold;
  logic [READING_W-1:0]        frame_reading [CHANNELS_DEF];
  logic [READING_W-1:0]        last_reading [CHANNELS_DEF];
  logic signed [TURN_W-1:0]    turns [CHANNELS_DEF];
  wheel_result_t               due_positions [$];
  int                          mismatches;
  int                          checked;
  int                          good_frames;
  int                          bad_frames;

  function new();
    header_byte = HEADER_RESET;
    wrap_high   = WRAP_HIGH_RESET;
    wrap_low    = WRAP_LOW_RESET;
    frame_pos   = 0;
    xor_fold    = '0;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      frame_reading[i] = '0;
      last_reading[i]  = '0;
      turns[i]         = '0;
    end
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_HEADER:    header_byte = value[BYTE_W-1:0];
      CFG_WRAP_HIGH: wrap_high   = value;
      CFG_WRAP_LOW:  wrap_low    = value;
      default: ;
    endcase
  endfunction

  function void take_byte(logic [BYTE_W-1:0] b);
    int unsigned k;
    int p;
    int a;
    wheel_result_t r;
    if (frame_pos == 0) begin
      if (b == header_byte) begin
        frame_pos = 1;
        xor_fold  = '0;
      end
      return;
    end
    if (frame_pos <= 2 * CHANNELS_DEF) begin
      k = frame_pos - 1;
      if (k[0] == 1'b0)
        frame_reading[k >> 1] = {b, 8'h00};
      else
        frame_reading[k >> 1][7:0] = b;
      xor_fold ^= b;
      frame_pos++;
      return;
    end
    // Checksum word: the frame ends here whether it is good or not.
    frame_pos = 0;
    if (b != xor_fold) begin
      bad_frames++;
      return;
    end
    good_frames++;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      if (last_reading[i] > wrap_high && frame_reading[i] < wrap_low)
        turns[i] = turns[i] + 8'sd1;
      if (last_reading[i] < wrap_low && frame_reading[i] > wrap_high)
        turns[i] = turns[i] - 8'sd1;
      last_reading[i] = frame_reading[i];
      p = int'(turns[i]) * 4096 + int'(frame_reading[i]);
      a = p * 15;
      r.channel     = CHAN_W'(i);
      r.raw_reading = frame_reading[i];
      r.turn_count  = turns[i];
      r.position    = POS_W'(p);
      r.angle_q9    = ANGLE_W'(a);
      r.last        = (i == CHANNELS_DEF - 1);
      due_positions.push_back(r);
    end
  endfunction

  function void compare_position(wheel_result_t got);
    wheel_result_t want;
    if (due_positions.size() == 0) begin
      $error("channel %0d: result arrived with nothing expected", got.channel);
      mismatches++;
      return;
    end
    want = due_positions.pop_front();
    checked++;
    if (got.channel !== want.channel) begin
      $error("channel: expected %0d, got %0d", want.channel, got.channel);
      mismatches++;
    end
    if (got.raw_reading !== want.raw_reading) begin
      $error("raw_reading: expected %0d, got %0d", want.raw_reading, got.raw_reading);
      mismatches++;
    end
    if (got.turn_count !== want.turn_count) begin
      $error("turn_count: expected %0d, got %0d", want.turn_count, got.turn_count);
      mismatches++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      mismatches++;
    end
    if (got.angle_q9 !== want.angle_q9) begin
      $error("angle_q9: expected %0d, got %0d", want.angle_q9, got.angle_q9);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 150;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic [BYTE_W-1:0]           in_rx_byte = '0;
  logic                        in_stall;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [CHAN_W-1:0]           out_channel;
  logic [READING_W-1:0]        out_raw_reading;
  logic signed [TURN_W-1:0]    out_turn_count;
  logic signed [POS_W-1:0]     out_position;
  logic signed [ANGLE_W-1:0]   out_angle_q9;
  logic                        out_last;
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_HEADER;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

  wheel_position_tracker tracker = new();
  wheel_result_t seen_word;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned header_mix_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stalled_cycles = 0;

  steer_encoder_frame_unwrap_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_rx_byte      (in_rx_byte),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel     (out_channel),
    .out_raw_reading (out_raw_reading),
    .out_turn_count  (out_turn_count),
    .out_position    (out_position),
    .out_angle_q9    (out_angle_q9),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.take_byte(in_rx_byte);
    if (rst_n && in_valid && in_stall)
      stalled_cycles++;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_word.channel     = out_channel;
      seen_word.raw_reading = out_raw_reading;
      seen_word.turn_count  = out_turn_count;
      seen_word.position    = out_position;
      seen_word.angle_q9    = out_angle_q9;
      seen_word.last        = out_last;
      tracker.compare_position(seen_word);
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends a header and data_bytes data bytes; a complete frame also gets its checksum,
  // spoilt on purpose when good is clear.
  task automatic send_frame(input logic [CHANNELS_DEF-1:0][READING_W-1:0] rd,
                            input int data_bytes, input bit good);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] fold;
    fold = '0;
    send_byte(tracker.header_byte);
    for (int k = 0; k < data_bytes; k++) begin
      b = k[0] ? rd[k >> 1][7:0] : rd[k >> 1][15:8];
      if ($urandom_range(99) < header_mix_pct)
        b = tracker.header_byte;
      fold ^= b;
      send_byte(b);
    end
    if (data_bytes == 2 * CHANNELS_DEF)
      send_byte(good ? fold : fold ^ BYTE_W'($urandom_range(255, 1)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.due_positions.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [BYTE_W-1:0] hdr, input logic [READING_W-1:0] hi,
                              input logic [READING_W-1:0] lo);
    logic [CFG_DATA_W-1:0] hdr_word;
    hdr_word = {8'($urandom), hdr};
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_wdata <= hdr_word;
    @(posedge clk);
    cfg_index <= CFG_WRAP_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_WRAP_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_register(CFG_HEADER, hdr_word);
    tracker.set_register(CFG_WRAP_HIGH, hi);
    tracker.set_register(CFG_WRAP_LOW, lo);
  endtask

  function automatic logic [READING_W-1:0] pick_reading();
    int hi;
    int lo;
    hi = int'(tracker.wrap_high);
    lo = int'(tracker.wrap_low);
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return (lo > 0) ? READING_W'($urandom_range(lo - 1, 0)) : 16'h0000;
      3: return (hi < 65535) ? READING_W'($urandom_range(65535, hi + 1)) : 16'hffff;
      4: return READING_W'($urandom_range(hi, lo));
      default: return READING_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHANNELS_DEF-1:0][READING_W-1:0] pick_frame();
    logic [CHANNELS_DEF-1:0][READING_W-1:0] rd;
    for (int i = 0; i < CHANNELS_DEF; i++)
      rd[i] = pick_reading();
    return rd;
  endfunction

  initial begin
    logic [BYTE_W-1:0]      hdr_set [6];
    logic [READING_W-1:0]   high_set [6];
    logic [READING_W-1:0]   low_set [6];
    logic [CHANNELS_DEF-1:0][READING_W-1:0] rd;
    int sent;
    int roll;
    int cut;

    hdr_set  = '{8'ha5, 8'h00, 8'hff, 8'h73, 8'h3c, 8'hc3};
    high_set = '{16'd40000, 16'd65535, 16'd100, 16'd3000, 16'd0, 16'd12000};
    low_set  = '{16'd20000, 16'd0, 16'd60000, 16'd1000, 16'd65535, 16'd500};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: stray words while hunting, then a frame whose data repeats the
    // header, then one with a spoilt checksum.
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame({16'h8000, 16'h7373, 16'h0000, 16'hffff}, 2 * CHANNELS_DEF, 1'b1);
    send_frame({16'h0102, 16'hfe00, 16'h0fff, 16'h00ff}, 2 * CHANNELS_DEF, 1'b0);

    header_mix_pct = 8;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      apply_config(hdr_set[ph], high_set[ph], low_set[ph]);
      tx_gap_pct   = (ph < 2) ? 28 : (ph < 4) ? 74 : 0;
      rx_stall_pct = (ph < 2) ? 74 : (ph < 4) ? 28 : 0;
      sent = 0;
      while (sent < 38) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          send_byte(BYTE_W'($urandom));
          sent++;
        end else if (roll < 14) begin
          cut = $urandom_range(2 * CHANNELS_DEF - 1, 0);
          send_frame(pick_frame(), cut, 1'b1);
          sent += cut + 1;
        end else if (roll < 17) begin
          wait_drained();
        end else begin
          send_frame(pick_frame(), 2 * CHANNELS_DEF, roll < 88);
          sent += 2 * CHANNELS_DEF + 2;
        end
      end
    end

    // Hold the output back long enough for the frame queue to fill and stall the input.
    settle();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_asks++;
    for (int f = 0; f < 4; f++)
      send_frame(pick_frame(), 2 * CHANNELS_DEF, 1'b1);

    // Walk every channel through whole turns: even channels count up, odd channels
    // count down, three frames per turn.
    settle();
    apply_config(HEADER_RESET, WRAP_HIGH_RESET, WRAP_LOW_RESET);
    header_mix_pct = 0;
    for (int t = 0; t < 2; t++) begin
      for (int s = 0; s < 3; s++) begin
        for (int i = 0; i < CHANNELS_DEF; i++) begin
          if (s == 2)
            rd[i] = READING_W'($urandom_range(3000, 1000));
          else if ((s == 0) == (i[0] == 1'b0))
            rd[i] = READING_W'($urandom_range(65535, 3001));
          else
            rd[i] = READING_W'($urandom_range(999, 0));
        end
        send_frame(rd, 2 * CHANNELS_DEF, 1'b1);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d wheel results from %0d good frames; %0d bad-checksum frames dropped.",
             tracker.checked, tracker.good_frames, tracker.bad_frames);
    $display("Input was stalled for %0d cycles; turn counters were walked both ways.",
             stalled_cycles);
    if (tracker.mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
